// ===== rtl/core/tdpt_pkg.sv =====
`timescale 1ns / 1ps

package tdpt_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_TEST,
    S_DONE
  } tdpt_state_t;

  typedef struct packed {
    logic load;
    logic start_div;
    logic step_div;
    logic next_div;
    logic set_result;
    logic result_val;
  } tdpt_cmd_t;

  typedef struct packed {
    logic lt2;
    logic sq_gt;
    logic div_last;
    logic rem_zero;
  } tdpt_status_t;

endpackage

// ===== rtl/core/tdpt_datapath.sv =====
`timescale 1ns / 1ps

module tdpt_datapath
  import tdpt_pkg::*;
#(
  parameter int NUM_WIDTH = 16
) (
  input  logic                 clk,
  input  logic [NUM_WIDTH-1:0] candidate,
  input  tdpt_cmd_t            cmd,
  output tdpt_status_t         status,
  output logic                 is_prime
);

  localparam int CNT_W = (NUM_WIDTH > 1) ? $clog2(NUM_WIDTH) : 1;

  logic [NUM_WIDTH-1:0] num;
  logic [NUM_WIDTH-1:0] div;
  logic [NUM_WIDTH+1:0] sq;
  logic [NUM_WIDTH-1:0] rem;
  logic [NUM_WIDTH-1:0] shreg;
  logic [CNT_W-1:0]     cnt;
  logic                 prime;

  logic [NUM_WIDTH:0]   trial;
  logic                 trial_ge;

  // restoring division, one quotient bit per cycle
  assign trial    = {rem, shreg[NUM_WIDTH-1]};
  assign trial_ge = trial >= {1'b0, div};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num <= candidate;
      div <= NUM_WIDTH'(2);
      sq  <= (NUM_WIDTH+2)'(4);
    end
    if (cmd.start_div) begin
      rem   <= '0;
      shreg <= num;
      cnt   <= '0;
    end
    if (cmd.step_div) begin
      if (trial_ge) begin
        rem <= NUM_WIDTH'(trial - {1'b0, div});
      end else begin
        rem <= trial[NUM_WIDTH-1:0];
      end
      shreg <= {shreg[NUM_WIDTH-2:0], 1'b0};
      cnt   <= cnt + CNT_W'(1);
    end
    if (cmd.next_div) begin
      // (d+1)^2 = d^2 + 2d + 1
      sq  <= sq + {1'b0, div, 1'b1};
      div <= div + NUM_WIDTH'(1);
    end
    if (cmd.set_result) begin
      prime <= cmd.result_val;
    end
  end

  always_comb begin
    status.lt2      = num < NUM_WIDTH'(2);
    status.sq_gt    = sq > {2'b00, num};
    status.div_last = cnt == CNT_W'(NUM_WIDTH - 1);
    status.rem_zero = rem == '0;
  end

  assign is_prime = prime;

endmodule

// ===== rtl/core/tdpt_controller.sv =====
`timescale 1ns / 1ps

module tdpt_controller
  import tdpt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  tdpt_status_t status,
  output tdpt_cmd_t    cmd,
  output logic         busy,
  output logic         done
);

  tdpt_state_t state;
  tdpt_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (status.lt2 || status.sq_gt) state_next = S_DONE;
        else state_next = S_DIV;
      end
      S_DIV: begin
        if (status.div_last) state_next = S_TEST;
      end
      S_TEST: begin
        if (status.rem_zero) state_next = S_DONE;
        else state_next = S_CHECK;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_CHECK: begin
        if (status.lt2) begin
          cmd.set_result = 1'b1;
          cmd.result_val = 1'b0;
        end else if (status.sq_gt) begin
          cmd.set_result = 1'b1;
          cmd.result_val = 1'b1;
        end else begin
          cmd.start_div = 1'b1;
        end
      end
      S_DIV: begin
        cmd.step_div = 1'b1;
      end
      S_TEST: begin
        if (status.rem_zero) begin
          cmd.set_result = 1'b1;
          cmd.result_val = 1'b0;
        end else begin
          cmd.next_div = 1'b1;
        end
      end
      S_DONE: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

`ifndef SYNTH
  a_start_check: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_CHECK))
    else $error("request accepted but no check started");

  a_div_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && !status.div_last) |=> (state == S_DIV))
    else $error("division left early");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done)
    else $error("result strobe not followed by idle");

  a_result_set: assert property (@(posedge clk) disable iff (rst)
    (state_next == S_DONE && state != S_DONE) |-> cmd.set_result)
    else $error("result not latched before strobe");
`endif

endmodule

// ===== rtl/core/trial_division_prime_test_core.sv =====
`timescale 1ns / 1ps
// For candidates below 4 the check state goes straight to done; otherwise each divisor
// tried (at most floor(sqrt(candidate)) - 1 of them) passes through a check state, the
// bit-serial restoring divider and a test state, and the search stops at the first
// divisor that leaves no remainder or once the divisor squared exceeds the candidate.
// A new request is taken only in idle; busy stays high through done and
// the receiver cannot stall. rst (synchronous) returns to idle with nothing pending.

module trial_division_prime_test_core
  import tdpt_pkg::*;
#(
  parameter int NUM_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [NUM_WIDTH-1:0] candidate,
  output logic                 busy,
  output logic                 done,
  output logic                 is_prime
);

  tdpt_cmd_t    cmd;
  tdpt_status_t status;

  tdpt_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  tdpt_datapath #(
    .NUM_WIDTH (NUM_WIDTH)
  ) u_dp (
    .clk       (clk),
    .candidate (candidate),
    .cmd       (cmd),
    .status    (status),
    .is_prime  (is_prime)
  );

endmodule

// ===== tb/trial_division_prime_test_core_tb.sv =====
`timescale 1ns / 1ps

module trial_division_prime_test_core_tb;

  localparam int NW = 16;
  localparam int RANDOM_ITEMS = 120;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 8;

  class prime_scoreboard;
    typedef struct {
      logic [NW-1:0] cand;
      bit            prime;
    } verdict_t;

    verdict_t verdicts[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    function bit compute_primality(logic [NW-1:0] n);
      int unsigned d;
      if (n < 2) return 1'b0;
      for (d = 2; d * d <= n; d++) begin
        if (n % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_request(logic [NW-1:0] cand);
      verdict_t v;
      v.cand  = cand;
      v.prime = compute_primality(cand);
      verdicts.push_back(v);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic got);
      verdict_t v;
      if (verdicts.size() == 0) begin
        report_mismatch($sformatf("is_prime=%b with no request pending", got));
      end else begin
        v = verdicts.pop_front();
        if (got !== v.prime)
          report_mismatch($sformatf("candidate %0d: is_prime=%b, want %b",
                                    v.cand, got, v.prime));
      end
    endtask

    function int pending();
      return verdicts.size();
    endfunction
  endclass

  logic          clk;
  logic          rst;
  logic          start;
  logic [NW-1:0] candidate;
  logic          busy;
  logic          done;
  logic          is_prime;

  prime_scoreboard sb;
  int              idle_cycles;
  bit              burst_mode;

  logic [NW-1:0] directed_vals [20] = '{
    16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd9, 16'd25, 16'd49,
    16'd121, 16'd289, 16'd63001, 16'd65521, 16'd65535, 16'd32768, 16'd32749,
    16'd65534, 16'd65025, 16'd97
  };

  trial_division_prime_test_core #(
    .NUM_WIDTH(NW)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .candidate(candidate),
    .busy(busy),
    .done(done),
    .is_prime(is_prime)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function logic [NW-1:0] pick_candidate();
    int unsigned a;
    int unsigned b;
    a = $urandom_range(2, 255);
    b = $urandom_range(2, 255);
    case ($urandom_range(0, 4))
      0: return NW'($urandom_range(0, 300));
      1: return NW'($urandom);
      2: return NW'($urandom) | NW'(1);
      3: return NW'(a * a);
      default: return NW'(a * b);
    endcase
  endfunction

  task send_request(logic [NW-1:0] cand);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    candidate <= cand;
    do @(posedge clk); while (busy);
    sb.note_request(cand);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (done) sb.check_result(is_prime);
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[trial_division_prime_test_core] ERROR");
        $finish;
      end
    end
  end

  initial begin
    sb         = new();
    burst_mode = 1'b0;
    rst        = 1'b1;
    start      = 1'b0;
    candidate  = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_vals[i]) send_request(directed_vals[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 20 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      send_request(pick_candidate());
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("[trial_division_prime_test_core] OK");
    end else begin
      $display("[trial_division_prime_test_core] ERROR");
    end
    $finish;
  end

endmodule
